@@ sv/pwc_pkg.sv @@
// Shared types and constants for the pulse width classifier.
// No dependencies; imported by pulse_width_classifier.
`timescale 1ns / 1ps
`default_nettype none

package pwc_pkg;

    // Configuration port widths
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 8;

    // Register field widths
    localparam int THRESH_W = 5;
    localparam int LIMIT_W  = 8;
    localparam int RUN_W    = 8;

    typedef logic [CFG_INDEX_W-1:0] t_cfg_index;
    typedef logic [THRESH_W-1:0]    t_thresh;
    typedef logic [LIMIT_W-1:0]     t_limit;
    typedef logic [RUN_W-1:0]       t_run;

    // Register indexes
    localparam t_cfg_index CFG_ACTIVE_THRESHOLD = 2'd0;
    localparam t_cfg_index CFG_SHORT_LIMIT      = 2'd1;
    localparam t_cfg_index CFG_LONG_LIMIT       = 2'd2;

    // Register reset values
    localparam t_thresh THRESH_RESET      = 5'd2;
    localparam t_limit  SHORT_LIMIT_RESET = 8'd18;
    localparam t_limit  LONG_LIMIT_RESET  = 8'd35;

    // Run counter saturation point
    localparam t_run RUN_MAX = 8'd255;

endpackage

`default_nettype wire

@@ sv/pulse_width_classifier.sv @@
// Pulse width classifier top level: moving window sum, run length check.
// Depends on pwc_pkg.
`timescale 1ns / 1ps
`default_nettype none

// One receiver pin sample is taken per request and one request can be
// accepted every clock cycle while the output does not stall. A sample passes
// an input register and then the window/run logic into the result register;
// a stall on the output can hold it in the input register. The first WINDOW
// samples after reset only fill the window and give no result; every later
// sample gives exactly one result. The input register lets a new sample in
// while a result waits to be taken, so a stall on the output costs at most
// one further request before the input side stops. Reset needs no clearing
// pass; configuration writes complete in the cycle they are presented.
module pulse_width_classifier
    import pwc_pkg::*;
#(
    parameter int WINDOW = 10
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    // sample channel
    input  wire logic             i_in_valid,
    output logic                  o_in_ready,
    input  wire logic             i_sample_bit,
    // result channel
    output logic                  o_out_valid,
    input  wire logic             i_out_ready,
    output logic                  o_line_active,
    output logic                  o_short_flag,
    output logic                  o_long_flag,
    output logic                  o_heartbeat,
    // configuration channel
    input  wire logic             i_cfg_valid,
    output logic                  o_cfg_ready,
    input  wire t_cfg_index       i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int CNT_W = $clog2(WINDOW + 1);
    localparam logic [CNT_W-1:0] WIN_FULL = CNT_W'(WINDOW);

    // Configuration registers
    t_thresh r_thresh;
    t_limit  r_short_limit;
    t_limit  r_long_limit;

    // Input register
    logic r_in_valid;
    logic r_in_bit;

    // Window and run state
    logic [WINDOW-1:0] r_ring;
    logic [CNT_W-1:0]  r_sum;
    logic [CNT_W-1:0]  r_prime_count;
    logic              r_was_active;
    t_run              r_run;
    logic              r_toggle;
    logic              r_short_held;
    logic              r_long_held;

    // Result register
    logic r_out_valid;
    logic r_out_active;
    logic r_out_short;
    logic r_out_long;
    logic r_out_beat;

    logic              primed;
    logic              out_free;
    logic              step;
    logic              emit;
    logic [CNT_W-1:0]  n_sum;
    logic              active;
    logic              n_short_held;
    logic              n_long_held;
    t_run              n_run;
    t_run              run_base;

    assign o_cfg_ready = 1'b1;

    // Write configuration registers; unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thresh      <= THRESH_RESET;
            r_short_limit <= SHORT_LIMIT_RESET;
            r_long_limit  <= LONG_LIMIT_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_ACTIVE_THRESHOLD: r_thresh      <= i_cfg_data[THRESH_W-1:0];
                CFG_SHORT_LIMIT:      r_short_limit <= i_cfg_data[LIMIT_W-1:0];
                CFG_LONG_LIMIT:       r_long_limit  <= i_cfg_data[LIMIT_W-1:0];
                default: ;
            endcase
        end
    end

    // Handshake: a priming sample never needs the result register
    assign primed     = (r_prime_count == WIN_FULL);
    assign out_free   = !r_out_valid || i_out_ready;
    assign step       = r_in_valid && (out_free || !primed);
    assign emit       = step && primed;
    assign o_in_ready = !r_in_valid || step;

    // Hold the accepted sample until the window logic takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_bit <= i_sample_bit;
        end
    end

    // Window sum and run length update
    always_comb begin
        if (primed) begin
            n_sum = r_sum - CNT_W'(r_ring[WINDOW-1]) + CNT_W'(r_in_bit);
        end else begin
            n_sum = r_sum + CNT_W'(r_in_bit);
        end
        active       = (THRESH_W'(n_sum) <= r_thresh);
        n_short_held = r_short_held;
        n_long_held  = r_long_held;
        run_base     = r_run;
        n_run        = r_run;
        if (active) begin
            if (!r_was_active) begin
                if (r_run < r_short_limit) begin
                    n_short_held = 1'b1;
                end
                if (r_run > r_long_limit) begin
                    n_long_held = 1'b1;
                end
                run_base = '0;
            end
            n_run = (run_base < RUN_MAX) ? run_base + 1'b1 : run_base;
        end else begin
            n_short_held = 1'b0;
            n_long_held  = 1'b0;
        end
    end

    // Advance the window; the oldest sample sits at the top of the shift line
    always_ff @(posedge i_clk) begin
        if (step) begin
            r_ring <= {r_ring[WINDOW-2:0], r_in_bit};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum         <= '0;
            r_prime_count <= '0;
            r_was_active  <= 1'b0;
            r_run         <= '0;
            r_toggle      <= 1'b0;
            r_short_held  <= 1'b0;
            r_long_held   <= 1'b0;
        end else if (step) begin
            r_sum <= n_sum;
            if (!primed) begin
                r_prime_count <= r_prime_count + 1'b1;
            end else begin
                r_was_active <= active;
                r_run        <= n_run;
                r_toggle     <= !r_toggle;
                r_short_held <= n_short_held;
                r_long_held  <= n_long_held;
            end
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out_active <= active;
            r_out_short  <= n_short_held;
            r_out_long   <= n_long_held;
            r_out_beat   <= r_toggle;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_line_active = r_out_active;
    assign o_short_flag  = r_out_short;
    assign o_long_flag   = r_out_long;
    assign o_heartbeat   = r_out_beat;

`ifndef SYNTHESIS
    // No result leaves before the window has been filled
    a_no_early_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> primed)
        else $error("result before window filled");

    // Running sum matches the window contents once filled
    a_sum_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        primed |-> ($countones(r_ring) == int'(r_sum)))
        else $error("window sum out of step with window");

    // Flags are only raised on an active line
    a_flags_need_active: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_short_flag || o_long_flag) |-> o_line_active)
        else $error("flag raised on inactive line");

    // A stalled result keeps the next sample waiting in the input register
    a_stall_holds_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && primed && r_out_valid && !i_out_ready |=> r_in_valid)
        else $error("sample lost during output stall");
`endif

endmodule

`default_nettype wire

@@ tb/testbench.sv @@
// Self-checking testbench for the pulse width classifier.
// Depends on pwc_pkg and pulse_width_classifier; the expected results come from
// a predictor of the window sum and run length logic that runs beside the block.
`timescale 1ns / 1ps

module testbench;
    import pwc_pkg::*;

    localparam int WIN           = 10;
    localparam int IDLE_PERCENT  = 34;
    localparam int SETTLE_CYCLES = 8;
    localparam int STALL_LIMIT   = 1000;
    localparam int REPORT_LIMIT  = 10;

    // Index past the end of the register list; the block must ignore it
    localparam t_cfg_index CFG_UNUSED_INDEX = 2'd3;

    typedef struct packed {
        logic line_active;
        logic short_flag;
        logic long_flag;
        logic heartbeat;
    } t_pwc_result;

    typedef struct packed {
        t_cfg_index              idx;
        logic [CFG_DATA_W-1:0]   data;
    } t_reg_write;

    // Clock, reset and block inputs, all known from time zero
    logic                  clk;
    logic                  rst_n     = 1'b0;
    logic                  in_valid  = 1'b0;
    logic                  sample_bit = 1'b0;
    logic                  out_ready = 1'b0;
    logic                  cfg_valid = 1'b0;
    t_cfg_index            cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    logic o_in_ready;
    logic o_out_valid;
    logic o_line_active;
    logic o_short_flag;
    logic o_long_flag;
    logic o_heartbeat;
    logic o_cfg_ready;

    // Stimulus and expectation stores
    logic        sample_queue[$];
    t_reg_write  reg_write_queue[$];
    t_pwc_result predicted_results[$];

    bit calm = 1'b0;
    int fault_count    = 0;
    int samples_sent   = 0;
    int results_seen   = 0;
    int settings_used  = 1;
    int idle_cycles;

    // Predictor copy of the registers and the window/run state
    t_thresh         cfg_thresh  = THRESH_RESET;
    t_limit          cfg_short   = SHORT_LIMIT_RESET;
    t_limit          cfg_long    = LONG_LIMIT_RESET;
    logic [WIN-1:0]  win_bits    = '0;
    logic [4:0]      win_total   = '0;
    logic [4:0]      filled_count = '0;
    int              next_slot   = 0;
    logic            in_run      = 1'b0;
    t_run            run_count   = '0;
    logic            beat_bit    = 1'b0;
    logic            short_seen  = 1'b0;
    logic            long_seen   = 1'b0;

    pulse_width_classifier #(
        .WINDOW(WIN)
    ) uut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .o_in_ready    (o_in_ready),
        .i_sample_bit  (sample_bit),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (out_ready),
        .o_line_active (o_line_active),
        .o_short_flag  (o_short_flag),
        .o_long_flag   (o_long_flag),
        .o_heartbeat   (o_heartbeat),
        .i_cfg_valid   (cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (cfg_index),
        .i_cfg_data    (cfg_data)
    );

    initial begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Update the predictor registers; unknown indexes are dropped
    task automatic apply_reg_write(input t_cfg_index idx, input logic [CFG_DATA_W-1:0] data);
        case (idx)
            CFG_ACTIVE_THRESHOLD: cfg_thresh = data[THRESH_W-1:0];
            CFG_SHORT_LIMIT:      cfg_short  = data[LIMIT_W-1:0];
            CFG_LONG_LIMIT:       cfg_long   = data[LIMIT_W-1:0];
            default: ;
        endcase
    endtask

    // Advance the window by one sample and, once it is full, classify the line
    task automatic classify_sample(input logic s, output bit produced, output t_pwc_result res);
        logic active;
        res = '0;
        if (filled_count < WIN) begin
            // priming: fill the ring, no result
            win_bits[filled_count] = s;
            win_total = win_total + s;
            filled_count = filled_count + 1'b1;
            produced = 1'b0;
        end else begin
            win_total = win_total - win_bits[next_slot] + s;
            win_bits[next_slot] = s;
            next_slot = (next_slot + 1 >= WIN) ? 0 : next_slot + 1;
            res.heartbeat = beat_bit;
            beat_bit = ~beat_bit;
            active = (win_total <= cfg_thresh);
            if (active) begin
                // on entry, judge the previous run and restart the count
                if (!in_run) begin
                    if (run_count < cfg_short)
                        short_seen = 1'b1;
                    if (run_count > cfg_long)
                        long_seen = 1'b1;
                    run_count = '0;
                end
                if (run_count < RUN_MAX)
                    run_count = run_count + 1'b1;
                in_run = 1'b1;
            end else begin
                in_run = 1'b0;
                short_seen = 1'b0;
                long_seen = 1'b0;
            end
            res.line_active = active;
            res.short_flag = short_seen;
            res.long_flag = long_seen;
            produced = 1'b1;
        end
    endtask

    // Sample driver: predict on acceptance, then offer the next request or idle
    always @(posedge clk) begin
        bit          produced;
        t_pwc_result res;
        bit          taken;
        taken = 1'b0;
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && o_in_ready) begin
                classify_sample(sample_bit, produced, res);
                if (produced)
                    predicted_results.push_back(res);
                samples_sent++;
                taken = 1'b1;
            end
            if (!in_valid || taken) begin
                if (sample_queue.size() > 0 &&
                    (calm || $urandom_range(0, 99) >= IDLE_PERCENT)) begin
                    in_valid <= 1'b1;
                    sample_bit <= sample_queue.pop_front();
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Register write driver
    always @(posedge clk) begin
        t_reg_write w;
        if (!rst_n) begin
            cfg_valid <= 1'b0;
        end else if (!cfg_valid || o_cfg_ready) begin
            if (cfg_valid)
                apply_reg_write(cfg_index, cfg_data);
            if (reg_write_queue.size() > 0) begin
                w = reg_write_queue.pop_front();
                cfg_valid <= 1'b1;
                cfg_index <= w.idx;
                cfg_data <= w.data;
            end else begin
                cfg_valid <= 1'b0;
            end
        end
    end

    // Result side back-pressure
    always @(posedge clk) begin
        out_ready <= calm || ($urandom_range(0, 99) >= IDLE_PERCENT);
    end

    // Result monitor: compare each accepted result with the oldest prediction
    always @(posedge clk) begin
        t_pwc_result got;
        t_pwc_result want;
        if (rst_n && o_out_valid && out_ready) begin
            got = {o_line_active, o_short_flag, o_long_flag, o_heartbeat};
            results_seen++;
            if (predicted_results.size() == 0) begin
                fault_count++;
                if (fault_count <= REPORT_LIMIT)
                    $display("Result %0d arrived with no prediction pending: %b",
                             results_seen, got);
            end else begin
                want = predicted_results.pop_front();
                if (got.line_active !== want.line_active ||
                    got.short_flag !== want.short_flag ||
                    got.long_flag !== want.long_flag ||
                    got.heartbeat !== want.heartbeat) begin
                    fault_count++;
                    if (fault_count <= REPORT_LIMIT) begin
                        $write("Result %0d mismatch: expected active=%b short=%b",
                               results_seen, want.line_active, want.short_flag);
                        $write(" long=%b beat=%b, got active=%b short=%b",
                               want.long_flag, want.heartbeat, got.line_active,
                               got.short_flag);
                        $display(" long=%b beat=%b", got.long_flag, got.heartbeat);
                    end
                end
            end
        end
    end

    // Watchdog: end the run when no request moves for too long
    initial begin
        idle_cycles = 0;
        while (idle_cycles < STALL_LIMIT) begin
            @(posedge clk);
            if (!rst_n || (in_valid && o_in_ready) || (o_out_valid && out_ready) ||
                (cfg_valid && o_cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("Watchdog: no request moved for %0d cycles", STALL_LIMIT);
        $display("CHECK FAILED");
        $finish;
    end

    // Queue the three register writes and hold until all are taken
    task automatic program_regs(input logic [CFG_DATA_W-1:0] thresh_data,
                                input logic [CFG_DATA_W-1:0] short_data,
                                input logic [CFG_DATA_W-1:0] long_data);
        reg_write_queue.push_back('{CFG_ACTIVE_THRESHOLD, thresh_data});
        reg_write_queue.push_back('{CFG_SHORT_LIMIT, short_data});
        reg_write_queue.push_back('{CFG_LONG_LIMIT, long_data});
        settings_used++;
        while (reg_write_queue.size() != 0 || cfg_valid)
            @(negedge clk);
    endtask

    // Hold until every sample is taken and every result has come, then settle
    task automatic finish_phase();
        while (sample_queue.size() != 0 || in_valid || predicted_results.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // Push a run of the same level, with the odd flipped sample as noise
    task automatic push_level(input logic level, input int len);
        for (int k = 0; k < len; k++)
            sample_queue.push_back(($urandom_range(0, 15) == 0) ? ~level : level);
    endtask

    // Mostly low/high pulse pairs of random lengths, some bursts of random bits
    task automatic push_pulse_train(input int count, input int max_low, input int max_high);
        int start;
        start = sample_queue.size();
        while (sample_queue.size() - start < count) begin
            if ($urandom_range(0, 4) == 0) begin
                repeat ($urandom_range(1, 8))
                    sample_queue.push_back(1'($urandom_range(0, 1)));
            end else begin
                push_level(1'b0, $urandom_range(1, max_low));
                push_level(1'b1, $urandom_range(1, max_high));
            end
        end
    endtask

    initial begin
        logic [23:0] opening;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset settings: priming, entry straight after reset, then leave the run
        opening = 24'b1011011101_0000000000_1111;
        for (int k = 23; k >= 0; k--)
            sample_queue.push_back(opening[k]);
        finish_phase();

        // Narrow limits; also an ignored write past the register list
        reg_write_queue.push_back('{CFG_UNUSED_INDEX, 8'hA5});
        program_regs(8'd4, 8'd3, 8'd6);
        push_pulse_train(100, 20, 15);
        finish_phase();

        // Lowest threshold, limits that can never fire
        program_regs(8'd0, 8'd0, 8'd255);
        push_pulse_train(60, 40, 20);
        finish_phase();

        // Threshold masked to its width, far above the window: always active
        program_regs(8'hFF, 8'd255, 8'd0);
        push_pulse_train(50, 20, 20);
        finish_phase();

        // Threshold equal to the window size
        program_regs(CFG_DATA_W'(WIN), 8'd1, 8'd2);
        push_pulse_train(50, 20, 20);
        finish_phase();

        // No idling: saturate the run counter, then re-enter after a gap
        calm = 1'b1;
        program_regs(8'd3, 8'd255, 8'd254);
        push_level(1'b0, 280);
        push_level(1'b1, 15);
        push_level(1'b0, 25);
        push_pulse_train(60, 40, 20);
        finish_phase();
        calm = 1'b0;

        // Random settings within the field ranges
        program_regs(CFG_DATA_W'($urandom_range(0, 16)), CFG_DATA_W'($urandom_range(0, 60)),
                     CFG_DATA_W'($urandom_range(0, 80)));
        push_pulse_train(60, 60, 30);
        finish_phase();

        $display("Covered %0d samples under %0d register settings, %0d results compared.",
                 samples_sent, settings_used, results_seen);
        $display("Faults found: %0d", fault_count);
        if (fault_count == 0 && predicted_results.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

@@ pulse_width_classifier.f @@
sv/pwc_pkg.sv
sv/pulse_width_classifier.sv
tb/testbench.sv
